@@ src/gwfr_pkg.sv @@
// Package for the GW376.1 frame receiver.
// Holds the channel payload types, the frame constants, and the role and status codes.
// No dependencies.
package gwfr_pkg;

  localparam int FIXED_HEADER_BYTES = 6;
  localparam int LINK_HEADER_BYTES  = 8;
  localparam int TIME_TAG_BYTES     = 6;
  localparam int PASSWORD_BYTES     = 16;

  localparam int WIN_W  = 8 * (FIXED_HEADER_BYTES - 1);
  localparam int LEN_W  = 14;
  localparam int TAIL_W = $clog2(TIME_TAG_BYTES + PASSWORD_BYTES + 1);
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 3;

  localparam logic [7:0]  SYNC_BYTE = 8'h68;
  localparam logic [7:0]  END_BYTE  = 8'h16;
  localparam logic [15:0] BROADCAST = 16'hFFFF;

  localparam logic [7:0] AFN_RESET    = 8'h01;
  localparam logic [7:0] AFN_SET      = 8'h04;
  localparam logic [7:0] AFN_CONTROL  = 8'h05;
  localparam logic [7:0] AFN_AUTH     = 8'h06;
  localparam logic [7:0] AFN_RELAY    = 8'h10;

  localparam logic [2:0] ROLE_HUNT     = 3'd0;
  localparam logic [2:0] ROLE_FIXED    = 3'd1;
  localparam logic [2:0] ROLE_LINK     = 3'd2;
  localparam logic [2:0] ROLE_DATA     = 3'd3;
  localparam logic [2:0] ROLE_PASSWORD = 3'd4;
  localparam logic [2:0] ROLE_TIME_TAG = 3'd5;
  localparam logic [2:0] ROLE_CHECKSUM = 3'd6;
  localparam logic [2:0] ROLE_END      = 3'd7;

  localparam logic [1:0] STATUS_GOOD     = 2'd0;
  localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
  localparam logic [1:0] STATUS_NO_END   = 2'd2;
  localparam logic [1:0] STATUS_NO_FRAME = 2'd3;

  localparam logic [IDX_W-1:0] REG_CHECK_PID      = 3'd0;
  localparam logic [IDX_W-1:0] REG_PROTOCOL_ID    = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAX_LENGTH     = 3'd2;
  localparam logic [IDX_W-1:0] REG_LOCAL_AREA     = 3'd3;
  localparam logic [IDX_W-1:0] REG_LOCAL_TERMINAL = 3'd4;

  localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 14'd4096;
  localparam logic [1:0]       PROTOCOL_ID_RESET = 2'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  role;
    logic        frame_done;
    logic [1:0]  frame_status;
    logic        address_match;
    logic [7:0]  control;
    logic [15:0] area_code;
    logic [15:0] terminal;
    logic [7:0]  group_msa;
    logic [7:0]  function_code;
    logic [7:0]  sequence_res;
  } result_t;

endpackage

@@ src/gwfr_byte_if.sv @@
// Byte channel into the frame receiver: valid, ready and one received byte.
// Depends on gwfr_pkg.
interface gwfr_byte_if;
  logic              valid;
  logic              ready;
  gwfr_pkg::rx_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/gwfr_result_if.sv @@
// Result channel out of the frame receiver: valid, ready and one tagged result.
// Depends on gwfr_pkg.
interface gwfr_result_if;
  logic             valid;
  logic             ready;
  gwfr_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/gw376_frame_receiver_unit.sv @@
// Top level of the GW376.1 frame receiver: sync hunt, field capture, checksum and end check.
// Depends on gwfr_pkg, gwfr_byte_if and gwfr_result_if.
//
//   channel   dir   kind           payload
//   rx        in    valid/ready    rx_byte
//   tx        out   valid/ready    tagged byte, status and captured link header
//   config    in    write only     write_enable, reg_index, write_data
//
// One byte per cycle unless tx stalls; each result is registered at its transfer.
// rx is ready while the result register is empty or being taken in the same cycle.
// A stall on tx holds the result and all frame state until it is taken.
// Synchronous reset restores register defaults and resumes hunting at once.
module gw376_frame_receiver_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_enable,
  input  logic [gwfr_pkg::IDX_W-1:0]    reg_index,
  input  logic [gwfr_pkg::CFG_W-1:0]    write_data,
  gwfr_byte_if.sink                     rx,
  gwfr_result_if.source                 tx
);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_BODY    = 3'd1;
  localparam logic [2:0] PH_CSUM    = 3'd2;
  localparam logic [2:0] PH_END_OK  = 3'd3;
  localparam logic [2:0] PH_END_BAD = 3'd4;

  localparam int LW = gwfr_pkg::LEN_W;

  logic                         check_pid;
  logic [1:0]                   protocol_id;
  logic [LW-1:0]                max_length;
  logic [15:0]                  local_area;
  logic [15:0]                  local_terminal;

  logic [gwfr_pkg::WIN_W-1:0]   window, window_next;
  logic [2:0]                   phase, phase_next;
  logic [LW-1:0]                byte_count, byte_count_next;
  logic [LW-1:0]                frame_length, frame_length_next;
  logic [7:0]                   running_sum, running_sum_next;
  logic [7:0]                   hf [gwfr_pkg::LINK_HEADER_BYTES];
  logic [7:0]                   hf_next [gwfr_pkg::LINK_HEADER_BYTES];

  logic                         out_valid;
  logic [7:0]                   out_byte;
  logic [2:0]                   role, role_next;
  logic                         done, done_next;
  logic [1:0]                   status, status_next;
  logic                         match, match_next;

  logic                         accept;
  logic [7:0]                   b;
  logic [47:0]                  w;
  logic [15:0]                  w1, w2;
  logic                         hdr_ok;
  logic [LW-1:0]                cnt_inc;
  logic [LW-1:0]                rem;
  logic [gwfr_pkg::TAIL_W-1:0]  tp, pw, tail;
  logic [15:0]                  a1, a2;

  assign b        = rx.data.rx_byte;
  assign rx.ready = !out_valid || tx.ready;
  assign accept   = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_pid      <= 1'b1;
      protocol_id    <= gwfr_pkg::PROTOCOL_ID_RESET;
      max_length     <= gwfr_pkg::MAX_LENGTH_RESET;
      local_area     <= '0;
      local_terminal <= '0;
    end else if (write_enable) begin
      case (reg_index)
        gwfr_pkg::REG_CHECK_PID:      check_pid      <= write_data[0];
        gwfr_pkg::REG_PROTOCOL_ID:    protocol_id    <= write_data[1:0];
        gwfr_pkg::REG_MAX_LENGTH:     max_length     <= write_data[LW-1:0];
        gwfr_pkg::REG_LOCAL_AREA:     local_area     <= write_data[15:0];
        gwfr_pkg::REG_LOCAL_TERMINAL: local_terminal <= write_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    w      = {window, b};
    w1     = {w[31:24], w[39:32]};
    w2     = {w[15:8], w[23:16]};
    hdr_ok = (w[47:40] == gwfr_pkg::SYNC_BYTE) && (w[7:0] == gwfr_pkg::SYNC_BYTE) &&
             (w1[15:2] <= max_length) && (w1[15:2] == w2[15:2]) &&
             (!check_pid || ((w1[1:0] == protocol_id) && (w2[1:0] == protocol_id)));

    cnt_inc = byte_count + LW'(1);
    rem     = frame_length - byte_count;
    tp      = hf[7][7] ? gwfr_pkg::TAIL_W'(gwfr_pkg::TIME_TAG_BYTES) : '0;
    pw      = (hf[6] inside {gwfr_pkg::AFN_RESET, gwfr_pkg::AFN_SET, gwfr_pkg::AFN_CONTROL,
                             gwfr_pkg::AFN_AUTH, gwfr_pkg::AFN_RELAY})
              ? gwfr_pkg::TAIL_W'(gwfr_pkg::PASSWORD_BYTES) : '0;
    tail    = tp + pw;
    a1      = {hf[2], hf[1]};
    a2      = {hf[4], hf[3]};

    window_next       = window;
    phase_next        = phase;
    byte_count_next   = byte_count;
    frame_length_next = frame_length;
    running_sum_next  = running_sum;
    hf_next           = hf;
    role_next         = gwfr_pkg::ROLE_HUNT;
    done_next         = 1'b0;
    status_next       = gwfr_pkg::STATUS_NO_FRAME;
    match_next        = 1'b0;

    case (phase)
      PH_BODY: begin
        if (byte_count < LW'(gwfr_pkg::LINK_HEADER_BYTES)) begin
          role_next = gwfr_pkg::ROLE_LINK;
          hf_next[byte_count[2:0]] = b;
        end else if (rem <= LW'(tp)) begin
          role_next = gwfr_pkg::ROLE_TIME_TAG;
        end else if (rem <= LW'(tail)) begin
          role_next = gwfr_pkg::ROLE_PASSWORD;
        end else begin
          role_next = gwfr_pkg::ROLE_DATA;
        end
        running_sum_next = running_sum + b;
        byte_count_next  = cnt_inc;
        if (cnt_inc >= frame_length) begin
          phase_next = PH_CSUM;
        end
      end
      PH_CSUM: begin
        role_next  = gwfr_pkg::ROLE_CHECKSUM;
        phase_next = (b == running_sum) ? PH_END_OK : PH_END_BAD;
      end
      PH_END_OK, PH_END_BAD: begin
        role_next = gwfr_pkg::ROLE_END;
        done_next = 1'b1;
        if (phase == PH_END_BAD) begin
          status_next = gwfr_pkg::STATUS_CHECKSUM;
        end else if (b != gwfr_pkg::END_BYTE) begin
          status_next = gwfr_pkg::STATUS_NO_END;
        end else begin
          status_next = gwfr_pkg::STATUS_GOOD;
        end
        match_next  = ((a1 == gwfr_pkg::BROADCAST) && (a2 == gwfr_pkg::BROADCAST)) ||
                      ((a1 == local_area) && (a2 == local_terminal));
        window_next = '0;
        phase_next  = PH_HUNT;
      end
      default: begin
        window_next = w[gwfr_pkg::WIN_W-1:0];
        phase_next  = PH_HUNT;
        if (hdr_ok) begin
          role_next         = gwfr_pkg::ROLE_FIXED;
          frame_length_next = w1[15:2];
          byte_count_next   = '0;
          running_sum_next  = '0;
          for (int i = 0; i < gwfr_pkg::LINK_HEADER_BYTES; i++) begin
            hf_next[i] = '0;
          end
          phase_next = (w1[15:2] == '0) ? PH_CSUM : PH_BODY;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window       <= '0;
      phase        <= PH_HUNT;
      byte_count   <= '0;
      frame_length <= '0;
      running_sum  <= '0;
      for (int i = 0; i < gwfr_pkg::LINK_HEADER_BYTES; i++) begin
        hf[i] <= '0;
      end
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        window       <= window_next;
        phase        <= phase_next;
        byte_count   <= byte_count_next;
        frame_length <= frame_length_next;
        running_sum  <= running_sum_next;
        hf           <= hf_next;
        out_valid    <= 1'b1;
      end else if (tx.ready) begin
        out_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte <= b;
      role     <= role_next;
      done     <= done_next;
      status   <= status_next;
      match    <= match_next;
    end
  end

  assign tx.valid = out_valid;

  always_comb begin
    tx.data.out_byte      = out_byte;
    tx.data.role          = role;
    tx.data.frame_done    = done;
    tx.data.frame_status  = status;
    tx.data.address_match = match;
    tx.data.control       = hf[0];
    tx.data.area_code     = {hf[2], hf[1]};
    tx.data.terminal      = {hf[4], hf[3]};
    tx.data.group_msa     = hf[5];
    tx.data.function_code = hf[6];
    tx.data.sequence_res  = hf[7];
  end

`ifndef NO_ASSERTIONS
  a_done_is_end: assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.data.frame_done |-> tx.data.role == gwfr_pkg::ROLE_END)
    else $error("frame_done without end role");

  a_idle_status: assert property (@(posedge clk) disable iff (rst)
    tx.valid && !tx.data.frame_done |->
      tx.data.frame_status == gwfr_pkg::STATUS_NO_FRAME && !tx.data.address_match)
    else $error("status reported off the end byte");

  a_body_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> byte_count < frame_length)
    else $error("byte count ran past frame length");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && (phase == PH_END_OK || phase == PH_END_BAD) |=>
      phase == PH_HUNT && window == '0)
    else $error("frame end did not resume hunting");
`endif

endmodule

@@ tb/sv/gw376_frame_receiver_unit_tb.sv @@
// Testbench for gw376_frame_receiver_unit: feeds received line bytes through the rx channel and
// checks every tagged result against a byte-level frame predictor kept in a scoreboard class.
// Depends on gwfr_pkg, gwfr_byte_if, gwfr_result_if and the receiver RTL.
module gw376_frame_receiver_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;

  typedef enum logic [2:0] {ST_HUNT, ST_BODY, ST_CSUM, ST_END_OK, ST_END_BAD} rx_phase_t;

  typedef struct packed {
    logic [7:0]  ctrl;
    logic [15:0] area;
    logic [15:0] term;
    logic [7:0]  grp;
    logic [7:0]  afn;
    logic [7:0]  seq;
  } link_hdr_t;

  class frame_scoreboard;
    bit          check_pid;
    logic [1:0]  pid;
    logic [13:0] max_len;
    logic [15:0] area;
    logic [15:0] term;

    rx_phase_t   phase;
    logic [47:0] window;
    logic [13:0] frame_len;
    int unsigned pos;
    logic [7:0]  sum;
    logic [7:0]  hdr [8];

    gwfr_pkg::result_t expected_q [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned frames_closed;
    int unsigned frames_good;

    function new();
      check_pid = 1'b1;
      pid       = gwfr_pkg::PROTOCOL_ID_RESET;
      max_len   = gwfr_pkg::MAX_LENGTH_RESET;
      area      = '0;
      term      = '0;
      phase     = ST_HUNT;
      window    = '0;
      frame_len = '0;
      pos       = 0;
      sum       = '0;
      foreach (hdr[i]) hdr[i] = '0;
    endfunction

    function void set_reg(logic [gwfr_pkg::IDX_W-1:0] idx, logic [gwfr_pkg::CFG_W-1:0] val);
      case (idx)
        gwfr_pkg::REG_CHECK_PID:      check_pid = val[0];
        gwfr_pkg::REG_PROTOCOL_ID:    pid = val[1:0];
        gwfr_pkg::REG_MAX_LENGTH:     max_len = val[13:0];
        gwfr_pkg::REG_LOCAL_AREA:     area = val;
        gwfr_pkg::REG_LOCAL_TERMINAL: term = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_byte(logic [7:0] b);
      gwfr_pkg::result_t r;
      logic [15:0] w1;
      logic [15:0] w2;
      bit          ok;
      int unsigned remain;
      int unsigned tag_n;
      int unsigned pw_n;
      r = '0;
      r.out_byte     = b;
      r.role         = gwfr_pkg::ROLE_HUNT;
      r.frame_status = gwfr_pkg::STATUS_NO_FRAME;
      case (phase)
        ST_BODY: begin
          if (pos < gwfr_pkg::LINK_HEADER_BYTES) begin
            r.role = gwfr_pkg::ROLE_LINK;
          end else begin
            remain = frame_len - pos;
            tag_n  = hdr[7][7] ? gwfr_pkg::TIME_TAG_BYTES : 0;
            pw_n   = (hdr[6] == gwfr_pkg::AFN_RESET || hdr[6] == gwfr_pkg::AFN_SET ||
                      hdr[6] == gwfr_pkg::AFN_CONTROL || hdr[6] == gwfr_pkg::AFN_AUTH ||
                      hdr[6] == gwfr_pkg::AFN_RELAY) ? gwfr_pkg::PASSWORD_BYTES : 0;
            if (remain <= tag_n) r.role = gwfr_pkg::ROLE_TIME_TAG;
            else if (remain <= tag_n + pw_n) r.role = gwfr_pkg::ROLE_PASSWORD;
            else r.role = gwfr_pkg::ROLE_DATA;
          end
          sum += b;
          if (pos < gwfr_pkg::LINK_HEADER_BYTES) hdr[pos] = b;
          pos++;
          if (pos >= frame_len) phase = ST_CSUM;
        end
        ST_CSUM: begin
          r.role = gwfr_pkg::ROLE_CHECKSUM;
          phase  = (b == sum) ? ST_END_OK : ST_END_BAD;
        end
        ST_END_OK, ST_END_BAD: begin
          r.role       = gwfr_pkg::ROLE_END;
          r.frame_done = 1'b1;
          if (phase == ST_END_BAD) r.frame_status = gwfr_pkg::STATUS_CHECKSUM;
          else if (b != gwfr_pkg::END_BYTE) r.frame_status = gwfr_pkg::STATUS_NO_END;
          else r.frame_status = gwfr_pkg::STATUS_GOOD;
          r.address_match = ({hdr[2], hdr[1]} == gwfr_pkg::BROADCAST &&
                             {hdr[4], hdr[3]} == gwfr_pkg::BROADCAST) ||
                            ({hdr[2], hdr[1]} == area && {hdr[4], hdr[3]} == term);
          frames_closed++;
          if (r.frame_status == gwfr_pkg::STATUS_GOOD) frames_good++;
          window = '0;
          phase  = ST_HUNT;
        end
        default: begin
          window = {window[39:0], b};
          w1 = {window[31:24], window[39:32]};
          w2 = {window[15:8], window[23:16]};
          ok = window[47:40] == gwfr_pkg::SYNC_BYTE && window[7:0] == gwfr_pkg::SYNC_BYTE;
          if (check_pid && (w1[1:0] != pid || w2[1:0] != pid)) ok = 1'b0;
          if (w1[15:2] > max_len || w1[15:2] != w2[15:2]) ok = 1'b0;
          if (ok) begin
            r.role    = gwfr_pkg::ROLE_FIXED;
            frame_len = w1[15:2];
            pos       = 0;
            sum       = '0;
            foreach (hdr[i]) hdr[i] = '0;
            phase = (w1[15:2] == 0) ? ST_CSUM : ST_BODY;
          end
        end
      endcase
      r.control       = hdr[0];
      r.area_code     = {hdr[2], hdr[1]};
      r.terminal      = {hdr[4], hdr[3]};
      r.group_msa     = hdr[5];
      r.function_code = hdr[6];
      r.sequence_res  = hdr[7];
      expected_q.push_back(r);
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: %s mismatch on result %0d: expected %0h, actual %0h",
                   $time, name, checked, want, got);
      end
    endfunction

    function void check_result(gwfr_pkg::result_t got);
      gwfr_pkg::result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: unexpected result: expected none, actual byte %0h role %0d",
                   $time, got.out_byte, got.role);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      compare("out_byte", 16'(e.out_byte), 16'(got.out_byte));
      compare("role", 16'(e.role), 16'(got.role));
      compare("frame_done", 16'(e.frame_done), 16'(got.frame_done));
      compare("frame_status", 16'(e.frame_status), 16'(got.frame_status));
      compare("address_match", 16'(e.address_match), 16'(got.address_match));
      compare("control", 16'(e.control), 16'(got.control));
      compare("area_code", e.area_code, got.area_code);
      compare("terminal", e.terminal, got.terminal);
      compare("group_msa", 16'(e.group_msa), 16'(got.group_msa));
      compare("function_code", 16'(e.function_code), 16'(got.function_code));
      compare("sequence_res", 16'(e.sequence_res), 16'(got.sequence_res));
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       write_enable;
  logic [gwfr_pkg::IDX_W-1:0] reg_index;
  logic [gwfr_pkg::CFG_W-1:0] write_data;

  gwfr_byte_if   rx_ch ();
  gwfr_result_if tx_ch ();

  frame_scoreboard sb = new();

  logic [7:0]  line_q [$];
  int unsigned bytes_sent;
  int          burst_left;
  int          settings_applied;
  int          idle_cycles;
  int          rx_mode;
  int          mode_left;

  gw376_frame_receiver_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .rx           (rx_ch),
    .tx           (tx_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (mode_left == 0) begin
      rx_mode   = $urandom_range(0, 2);
      mode_left = $urandom_range(24, 160);
    end
    mode_left--;
    case (rx_mode)
      0:       tx_ch.ready <= 1'b1;
      1:       tx_ch.ready <= ($urandom_range(0, 3) != 0);
      default: tx_ch.ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (tx_ch.valid && tx_ch.ready) sb.check_result(tx_ch.data);
      if (rx_ch.valid && rx_ch.ready) sb.note_byte(rx_ch.data.rx_byte);
      if ((tx_ch.valid && tx_ch.ready) || (rx_ch.valid && rx_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no transfer for %0d cycles", $time, idle_cycles);
        $display("gw376_frame_receiver_unit_tb failed");
        $finish;
      end
    end
  end

  function automatic link_hdr_t hdr_of(logic [7:0] ctrl, logic [15:0] area, logic [15:0] term,
                                       logic [7:0] grp, logic [7:0] afn, logic [7:0] seq);
    return '{ctrl, area, term, grp, afn, seq};
  endfunction

  function automatic link_hdr_t rand_hdr();
    link_hdr_t h;
    h.ctrl = 8'($urandom);
    h.grp  = 8'($urandom);
    h.seq  = 8'($urandom);
    h.area = 16'($urandom);
    h.term = 16'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        h.area = sb.area;
        h.term = sb.term;
      end
      3, 4: begin
        h.area = gwfr_pkg::BROADCAST;
        h.term = gwfr_pkg::BROADCAST;
      end
      5:       h.area = gwfr_pkg::BROADCAST;
      6:       h.area = sb.area;
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0:       h.afn = gwfr_pkg::AFN_RESET;
      1:       h.afn = gwfr_pkg::AFN_SET;
      2:       h.afn = gwfr_pkg::AFN_CONTROL;
      3:       h.afn = gwfr_pkg::AFN_AUTH;
      4:       h.afn = gwfr_pkg::AFN_RELAY;
      default: h.afn = 8'($urandom);
    endcase
    return h;
  endfunction

  function automatic logic [13:0] pick_length();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 8 && sb.max_len < 200) return sb.max_len + 14'($urandom_range(0, 1));
    if (r < 55) n = $urandom_range(0, 12);
    else if (r < 90) n = $urandom_range(13, 48);
    else n = $urandom_range(49, 160);
    if (n > sb.max_len && $urandom_range(0, 3) != 0) n = $urandom_range(0, sb.max_len);
    return 14'(n);
  endfunction

  task automatic queue_header(input logic [13:0] len_a, input logic [1:0] pid_a,
                              input logic [13:0] len_b, input logic [1:0] pid_b);
    logic [15:0] wa;
    logic [15:0] wb;
    wa = {len_a, pid_a};
    wb = {len_b, pid_b};
    line_q.push_back(gwfr_pkg::SYNC_BYTE);
    line_q.push_back(wa[7:0]);
    line_q.push_back(wa[15:8]);
    line_q.push_back(wb[7:0]);
    line_q.push_back(wb[15:8]);
    line_q.push_back(gwfr_pkg::SYNC_BYTE);
  endtask

  task automatic queue_frame(input logic [13:0] len, input logic [1:0] pid_a,
                             input logic [1:0] pid_b, input logic [13:0] len_b,
                             input link_hdr_t h, input bit bad_sum, input logic [7:0] tail);
    logic [7:0] hb [8];
    logic [7:0] b;
    logic [7:0] sum;
    hb[0] = h.ctrl;
    hb[1] = h.area[7:0];
    hb[2] = h.area[15:8];
    hb[3] = h.term[7:0];
    hb[4] = h.term[15:8];
    hb[5] = h.grp;
    hb[6] = h.afn;
    hb[7] = h.seq;
    sum = '0;
    queue_header(len, pid_a, len_b, pid_b);
    for (int i = 0; i < len; i++) begin
      b = (i < gwfr_pkg::LINK_HEADER_BYTES) ? hb[i] : 8'($urandom);
      sum += b;
      line_q.push_back(b);
    end
    line_q.push_back(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
    line_q.push_back(tail);
  endtask

  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 32);
      if (gap > 0) begin
        rx_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    rx_ch.valid        <= 1'b1;
    rx_ch.data.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    burst_left--;
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_line();
    while (line_q.size() != 0) push_byte(line_q.pop_front());
  endtask

  // hold the sender until every outstanding result has been taken
  task automatic wait_for_results();
    rx_ch.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [gwfr_pkg::IDX_W-1:0] idx,
                           input logic [gwfr_pkg::CFG_W-1:0] val);
    write_enable <= 1'b1;
    reg_index    <= idx;
    write_data   <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    write_enable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_config(input bit chk, input logic [1:0] id, input logic [13:0] maxl,
                              input logic [15:0] area, input logic [15:0] term);
    wait_for_results();
    repeat (2) @(negedge clk);
    write_reg(gwfr_pkg::REG_CHECK_PID, gwfr_pkg::CFG_W'(chk));
    write_reg(gwfr_pkg::REG_PROTOCOL_ID, gwfr_pkg::CFG_W'(id));
    write_reg(gwfr_pkg::REG_MAX_LENGTH, gwfr_pkg::CFG_W'(maxl));
    write_reg(gwfr_pkg::REG_LOCAL_AREA, area);
    write_reg(gwfr_pkg::REG_LOCAL_TERMINAL, term);
    settings_applied++;
  endtask

  task automatic run_random(input int unsigned quota);
    int unsigned start;
    logic [13:0] len;
    logic [13:0] len_b;
    logic [1:0]  pid_a;
    logic [1:0]  pid_b;
    start = bytes_sent;
    while (bytes_sent - start < quota) begin
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0)
        line_q.push_back(($urandom_range(0, 3) == 0) ? gwfr_pkg::SYNC_BYTE : 8'($urandom));
      len   = pick_length();
      pid_a = (!sb.check_pid || $urandom_range(0, 19) == 0) ? 2'($urandom) : sb.pid;
      pid_b = (!sb.check_pid || $urandom_range(0, 19) == 0) ? 2'($urandom) : sb.pid;
      len_b = ($urandom_range(0, 19) == 0) ? len ^ 14'(1 << $urandom_range(0, 13)) : len;
      if ($urandom_range(0, 24) == 0) begin
        // truncated header, then the frame starts over
        queue_header(len, pid_a, len_b, pid_b);
        repeat ($urandom_range(1, 5)) void'(line_q.pop_back());
      end
      queue_frame(len, pid_a, pid_b, len_b, rand_hdr(), $urandom_range(0, 5) == 0,
                  ($urandom_range(0, 6) == 0) ? 8'($urandom) : gwfr_pkg::END_BYTE);
      send_line();
      if ($urandom_range(0, 29) == 0) wait_for_results();
    end
  endtask

  initial begin
    rst          = 1'b1;
    write_enable = 1'b0;
    reg_index    = '0;
    write_data   = '0;
    rx_ch.valid  = 1'b0;
    rx_ch.data   = '0;
    tx_ch.ready  = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    line_q = '{8'h00, 8'hFF, gwfr_pkg::SYNC_BYTE, gwfr_pkg::END_BYTE};
    queue_frame(14'd0, gwfr_pkg::PROTOCOL_ID_RESET, gwfr_pkg::PROTOCOL_ID_RESET, 14'd0,
                hdr_of(8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00), 1'b0,
                gwfr_pkg::END_BYTE);
    queue_frame(14'd0, gwfr_pkg::PROTOCOL_ID_RESET, gwfr_pkg::PROTOCOL_ID_RESET, 14'd0,
                hdr_of(8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00), 1'b1, 8'h00);
    queue_frame(14'd3, gwfr_pkg::PROTOCOL_ID_RESET, gwfr_pkg::PROTOCOL_ID_RESET, 14'd3,
                hdr_of(8'h4B, 16'hA55A, 16'h1234, 8'h02, 8'h0C, 8'h60), 1'b0,
                gwfr_pkg::END_BYTE);
    queue_frame(14'd8, gwfr_pkg::PROTOCOL_ID_RESET, gwfr_pkg::PROTOCOL_ID_RESET, 14'd8,
                hdr_of(8'hFF, gwfr_pkg::BROADCAST, gwfr_pkg::BROADCAST, 8'hFF, 8'hFF, 8'h7F),
                1'b0, 8'h17);
    queue_frame(14'd30, gwfr_pkg::PROTOCOL_ID_RESET, gwfr_pkg::PROTOCOL_ID_RESET, 14'd30,
                hdr_of(8'h4A, 16'h0000, 16'h0000, 8'h01, gwfr_pkg::AFN_SET, 8'hE0), 1'b0,
                gwfr_pkg::END_BYTE);
    queue_frame(14'd20, gwfr_pkg::PROTOCOL_ID_RESET, gwfr_pkg::PROTOCOL_ID_RESET, 14'd20,
                hdr_of(8'h41, 16'h0000, 16'hFFFF, 8'h80, gwfr_pkg::AFN_RELAY, 8'h80), 1'b0,
                gwfr_pkg::END_BYTE);
    queue_frame(14'd12, gwfr_pkg::PROTOCOL_ID_RESET, gwfr_pkg::PROTOCOL_ID_RESET, 14'd12,
                hdr_of(8'hC4, 16'hFFFF, 16'h0000, 8'h10, gwfr_pkg::AFN_AUTH, 8'h80), 1'b0,
                gwfr_pkg::END_BYTE);
    queue_frame(14'd40, gwfr_pkg::PROTOCOL_ID_RESET, gwfr_pkg::PROTOCOL_ID_RESET, 14'd40,
                hdr_of(8'h4B, 16'h0000, 16'h0000, 8'h7E, gwfr_pkg::AFN_RESET, 8'h00), 1'b1,
                gwfr_pkg::END_BYTE);
    queue_frame(14'd26, gwfr_pkg::PROTOCOL_ID_RESET, gwfr_pkg::PROTOCOL_ID_RESET, 14'd26,
                hdr_of(8'h5A, 16'h0001, 16'h8000, 8'h55, gwfr_pkg::AFN_CONTROL, 8'h7F), 1'b0,
                gwfr_pkg::END_BYTE);
    queue_header(14'd5, 2'd1, 14'd5, gwfr_pkg::PROTOCOL_ID_RESET);
    queue_header(14'd5, gwfr_pkg::PROTOCOL_ID_RESET, 14'd6, gwfr_pkg::PROTOCOL_ID_RESET);
    queue_header(gwfr_pkg::MAX_LENGTH_RESET + 14'd1, gwfr_pkg::PROTOCOL_ID_RESET,
                 gwfr_pkg::MAX_LENGTH_RESET + 14'd1, gwfr_pkg::PROTOCOL_ID_RESET);
    line_q.push_back(gwfr_pkg::SYNC_BYTE);
    queue_frame(14'd9, gwfr_pkg::PROTOCOL_ID_RESET, gwfr_pkg::PROTOCOL_ID_RESET, 14'd9,
                hdr_of(8'h0B, 16'h3412, 16'h7856, 8'hAA, 8'h0D, 8'h81), 1'b0,
                gwfr_pkg::END_BYTE);
    send_line();

    apply_config(1'b0, 2'd0, 14'd16383, gwfr_pkg::BROADCAST, gwfr_pkg::BROADCAST);
    run_random(250);
    apply_config(1'b1, 2'd3, 14'd0, 16'h0000, 16'h0000);
    run_random(250);
    apply_config(1'b1, 2'd1, 14'd37, 16'($urandom), 16'($urandom));
    run_random(250);
    apply_config(1'b1, 2'd0, 14'd16383, 16'h0000, gwfr_pkg::BROADCAST);
    run_random(250);
    apply_config(1'b0, gwfr_pkg::PROTOCOL_ID_RESET, gwfr_pkg::MAX_LENGTH_RESET,
                 16'($urandom), 16'($urandom));
    run_random(250);
    apply_config(1'b1, 2'($urandom), 14'($urandom_range(8, 120)), 16'($urandom),
                 16'($urandom));
    run_random(250);

    wait_for_results();
    repeat (10) @(negedge clk);
    $display("%0d bytes sent and %0d results checked over %0d register settings",
             bytes_sent, sb.checked, settings_applied + 1);
    $display("%0d frames closed, %0d of them good, %0d mismatches",
             sb.frames_closed, sb.frames_good, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("gw376_frame_receiver_unit_tb passed");
    end else begin
      $display("gw376_frame_receiver_unit_tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/gwfr_pkg.sv
src/gwfr_byte_if.sv
src/gwfr_result_if.sv
src/gw376_frame_receiver_unit.sv
tb/sv/gw376_frame_receiver_unit_tb.sv
